### rtl/assert_macros.svh
// Assertion macros used by the checker file of the I2C sequencer.
// Each use expects signal clk, and all but I2CMS_ASSERT_RST also rst_n, in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while in reset
`define I2CMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, ignored while in reset
`define I2CMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication that also covers the reset cycles
`define I2CMS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### rtl/i2cms_pkg.sv
// Package of the I2C master transaction sequencer: codes, word types and
// default store depths. No dependencies.
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam int TX_DEPTH_DEF = 32;
  localparam int RX_DEPTH_DEF = 32;
  // Widest store address (depths go up to 256)
  localparam int STORE_AW_MAX = 8;

  typedef enum logic [2:0] {
    OP_LOAD_TX   = 3'd0,
    OP_START_WR  = 3'd1,
    OP_START_RD  = 3'd2,
    OP_BUS_EVENT = 3'd3,
    OP_READ_RX   = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    EV_START      = 4'd0,
    EV_REP_START  = 4'd1,
    EV_SLAW_ACK   = 4'd2,
    EV_SLAW_NACK  = 4'd3,
    EV_DATA_ACK   = 4'd4,
    EV_DATA_NACK  = 4'd5,
    EV_ARB_LOST   = 4'd6,
    EV_SLAR_ACK   = 4'd7,
    EV_SLAR_NACK  = 4'd8,
    EV_RX_ACK     = 4'd9,
    EV_RX_NACK    = 4'd10,
    EV_NONE       = 4'd11,
    EV_ILLEGAL    = 4'd12
  } event_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_NACK  = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_READY   = 3'd0,
    MODE_INIT    = 3'd1,
    MODE_REPSENT = 3'd2,
    MODE_TX      = 3'd3,
    MODE_RX      = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_BUSY      = 3'd1,
    ERR_SLAR_NACK = 3'd2,
    ERR_SLAW_NACK = 3'd3,
    ERR_DATA_NACK = 3'd4,
    ERR_ARB_LOST  = 3'd5,
    ERR_ILLEGAL   = 3'd6
  } err_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic [6:0] device_address;
    logic [5:0] length;
    logic       repeated_start;
    logic [3:0] event_code;
    logic [4:0] index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] tx_byte;
    logic [7:0] rx_data;
    logic [2:0] bus_mode;
    logic [2:0] error_status;
    logic       accepted;
    logic       finished;
  } out_item_t;

  // Access to one byte store: one write and one registered read per cycle
  typedef struct packed {
    logic                    we;
    logic [STORE_AW_MAX-1:0] waddr;
    logic [7:0]              wdata;
    logic                    re;
    logic [STORE_AW_MAX-1:0] raddr;
  } store_req_t;

  // Registered decision, merged with store read data at the output
  typedef struct packed {
    cmd_e       cmd;
    mode_e      mode;
    err_e       err;
    logic       acc;
    logic       fin;
    logic       tx_sel;
    logic       tx_fwd;
    logic [7:0] tx_fwd_byte;
    logic       rx_sel;
  } res_t;

endpackage

### rtl/i2cms_store.sv
// Byte store with one write port and one registered read port.
// Depends on i2cms_pkg for the access request type.
`timescale 1ns / 1ps

module i2cms_store #(
  parameter int DEPTH = i2cms_pkg::TX_DEPTH_DEF
) (
  input  logic                   clk,
  input  i2cms_pkg::store_req_t  req,
  output logic [7:0]             rd_data_r
);
  import i2cms_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    // hold the last read while no new read is issued
    if (req.re) begin
      rd_data_r <= mem[req.raddr[AW-1:0]];
    end
  end

endmodule

### rtl/i2cms_ctrl.sv
// Transaction state and per-word decision logic of the I2C sequencer.
// Depends on i2cms_pkg; drives the two byte stores and the result register.
`timescale 1ns / 1ps

module i2cms_ctrl #(
  parameter int TX_DEPTH = i2cms_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = i2cms_pkg::RX_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  i2cms_pkg::in_item_t   item,
  input  logic                  advance,
  output i2cms_pkg::store_req_t tx_req,
  output i2cms_pkg::store_req_t rx_req,
  output i2cms_pkg::res_t       res_r
);
  import i2cms_pkg::*;

  localparam int TXC_W = $clog2(TX_DEPTH + 1);
  localparam int RXC_W = $clog2(RX_DEPTH + 1);

  logic [TXC_W-1:0] tx_count_r, tx_count_nxt;
  logic [TXC_W-1:0] tx_pos_r, tx_pos_nxt;
  logic [RXC_W-1:0] rx_count_r, rx_count_nxt;
  logic [RXC_W-1:0] rx_pos_r, rx_pos_nxt;
  mode_e            mode_r, mode_nxt;
  err_e             err_r, err_nxt;
  logic             hold_r, hold_nxt;
  res_t             res_nxt;

  logic             ready_m;
  logic             reject;
  logic             do_launch;
  logic             do_finish;
  err_e             fin_err;
  logic             rx_next;
  logic [RXC_W:0]   pos_inc;
  logic [7:0]       rd_addr_byte;

  assign ready_m      = (mode_r == MODE_READY) || (mode_r == MODE_REPSENT);
  assign rd_addr_byte = {item.device_address, 1'b1};

  always_comb begin
    tx_count_nxt = tx_count_r;
    tx_pos_nxt   = tx_pos_r;
    rx_count_nxt = rx_count_r;
    rx_pos_nxt   = rx_pos_r;
    mode_nxt     = mode_r;
    err_nxt      = err_r;
    hold_nxt     = hold_r;
    tx_req       = '0;
    rx_req       = '0;
    reject       = 1'b0;
    do_launch    = 1'b0;
    do_finish    = 1'b0;
    fin_err      = ERR_OK;
    rx_next      = 1'b0;
    pos_inc      = '0;
    res_nxt      = '0;
    res_nxt.cmd  = CMD_NONE;

    unique case (op_e'(item.operation))
      OP_LOAD_TX: begin
        if (int'(item.index) < TX_DEPTH) begin
          tx_req.we    = 1'b1;
          tx_req.waddr = STORE_AW_MAX'(item.index);
          tx_req.wdata = item.data_byte;
        end
      end
      OP_START_WR: begin
        if (!ready_m || int'(item.length) > TX_DEPTH) begin
          reject = 1'b1;
        end else begin
          res_nxt.acc  = 1'b1;
          hold_nxt     = item.repeated_start;
          tx_count_nxt = TXC_W'(item.length);
          do_launch    = 1'b1;
        end
      end
      OP_START_RD: begin
        if (!ready_m || int'(item.length) > RX_DEPTH) begin
          reject = 1'b1;
        end else begin
          res_nxt.acc  = 1'b1;
          rx_pos_nxt   = '0;
          rx_count_nxt = RXC_W'(item.length);
          // address byte goes to slot zero; forward it if sent at once
          tx_req.we    = 1'b1;
          tx_req.waddr = '0;
          tx_req.wdata = rd_addr_byte;
          res_nxt.tx_fwd      = 1'b1;
          res_nxt.tx_fwd_byte = rd_addr_byte;
          tx_count_nxt = TXC_W'(1);
          hold_nxt     = item.repeated_start;
          do_launch    = 1'b1;
        end
      end
      OP_BUS_EVENT: begin
        unique case (event_e'(item.event_code))
          EV_START, EV_SLAW_ACK, EV_DATA_ACK: begin
            if (event_e'(item.event_code) == EV_SLAW_ACK) begin
              mode_nxt = MODE_TX;
            end
            if (tx_pos_r < tx_count_r) begin
              tx_req.re      = 1'b1;
              tx_req.raddr   = STORE_AW_MAX'(tx_pos_r);
              res_nxt.tx_sel = 1'b1;
              tx_pos_nxt     = tx_pos_r + 1'b1;
              err_nxt        = ERR_OK;
              res_nxt.cmd    = CMD_SEND;
            end else begin
              do_finish = 1'b1;
            end
          end
          EV_SLAR_ACK: begin
            mode_nxt = MODE_RX;
            rx_next  = 1'b1;
          end
          EV_RX_ACK, EV_RX_NACK: begin
            if (int'(rx_pos_r) < RX_DEPTH) begin
              rx_req.we    = 1'b1;
              rx_req.waddr = STORE_AW_MAX'(rx_pos_r);
              rx_req.wdata = item.data_byte;
              rx_pos_nxt   = rx_pos_r + 1'b1;
            end
            if (event_e'(item.event_code) == EV_RX_ACK) begin
              rx_next = 1'b1;
            end else begin
              do_finish = 1'b1;
            end
          end
          EV_SLAR_NACK: begin
            do_finish = 1'b1;
            fin_err   = ERR_SLAR_NACK;
          end
          EV_SLAW_NACK: begin
            do_finish = 1'b1;
            fin_err   = ERR_SLAW_NACK;
          end
          EV_DATA_NACK: begin
            do_finish = 1'b1;
            fin_err   = ERR_DATA_NACK;
          end
          EV_ARB_LOST: begin
            do_finish = 1'b1;
            fin_err   = ERR_ARB_LOST;
          end
          EV_REP_START: begin
            mode_nxt = MODE_REPSENT;
          end
          EV_ILLEGAL: begin
            err_nxt     = ERR_ILLEGAL;
            mode_nxt    = MODE_READY;
            res_nxt.cmd = CMD_STOP;
            res_nxt.fin = 1'b1;
          end
          default: begin
          end
        endcase
      end
      OP_READ_RX: begin
        if (int'(item.index) < RX_DEPTH) begin
          rx_req.re      = 1'b1;
          rx_req.raddr   = STORE_AW_MAX'(item.index);
          res_nxt.rx_sel = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // begin a transfer: straight to data after a repeated start
    if (do_launch) begin
      mode_nxt = MODE_INIT;
      if (mode_r == MODE_REPSENT) begin
        tx_req.re      = 1'b1;
        tx_req.raddr   = '0;
        res_nxt.tx_sel = 1'b1;
        tx_pos_nxt     = TXC_W'(1);
        res_nxt.cmd    = CMD_SEND;
      end else begin
        tx_pos_nxt  = '0;
        res_nxt.cmd = CMD_START;
      end
    end

    // ACK while more bytes follow the one now requested, NACK on the last
    if (rx_next) begin
      err_nxt     = ERR_OK;
      pos_inc     = {1'b0, rx_pos_nxt} + (RXC_W + 1)'(1);
      res_nxt.cmd = (pos_inc < {1'b0, rx_count_r}) ? CMD_ACK : CMD_NACK;
    end

    // end of transfer: keep the bus with a new start, or stop
    if (do_finish) begin
      err_nxt = fin_err;
      if (hold_r) begin
        res_nxt.cmd = CMD_START;
      end else begin
        mode_nxt    = MODE_READY;
        res_nxt.fin = 1'b1;
        res_nxt.cmd = CMD_STOP;
      end
    end

    res_nxt.mode = mode_nxt;
    res_nxt.err  = reject ? ERR_BUSY : err_nxt;

    if (!advance) begin
      tx_req = '0;
      rx_req = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_count_r <= '0;
      tx_pos_r   <= '0;
      rx_count_r <= '0;
      rx_pos_r   <= '0;
      mode_r     <= MODE_READY;
      err_r      <= ERR_OK;
      hold_r     <= 1'b0;
    end else if (advance) begin
      tx_count_r <= tx_count_nxt;
      tx_pos_r   <= tx_pos_nxt;
      rx_count_r <= rx_count_nxt;
      rx_pos_r   <= rx_pos_nxt;
      mode_r     <= mode_nxt;
      err_r      <= err_nxt;
      hold_r     <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

endmodule

### rtl/i2c_master_transaction_sequencer.sv
// I2C master transaction sequencer, top level.
// Channels: in_valid/in_ready/in_data carry one request word (load tx byte,
// start write, start read, bus event, read rx byte); out_valid/out_ready/
// out_data return exactly one result word per request, in order.
// Pipeline: an input register, the decision logic with the store accesses,
// and a result register merged with the store read data.
// Throughput is one word per cycle while the receiver does not stall, and each
// word needs at most one write and one read of each store.
// When the receiver stalls, the result register holds and one more word
// waits in the input register; in_ready drops only while both are full.
// Synchronous reset (rst_n low) empties the pipeline, clears counters and
// positions, sets the bus mode to ready and the error to ok. The stores are
// not cleared; bytes must be loaded or received before they are read.
// Depends on i2cms_pkg, i2cms_ctrl and i2cms_store.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer #(
  parameter int TX_DEPTH = i2cms_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = i2cms_pkg::RX_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cms_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cms_pkg::out_item_t out_data
);
  import i2cms_pkg::*;

  logic       s1_v_r;
  in_item_t   in_r;
  logic       out_v_r;
  logic       advance;
  store_req_t tx_req;
  store_req_t rx_req;
  res_t       res_r;
  logic [7:0] tx_rd;
  logic [7:0] rx_rd;

  assign advance   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready  = !s1_v_r || advance;
  assign out_valid = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  i2cms_ctrl #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (in_r),
    .advance (advance),
    .tx_req  (tx_req),
    .rx_req  (rx_req),
    .res_r   (res_r)
  );

  i2cms_store #(
    .DEPTH (TX_DEPTH)
  ) u_tx_store (
    .clk       (clk),
    .req       (tx_req),
    .rd_data_r (tx_rd)
  );

  i2cms_store #(
    .DEPTH (RX_DEPTH)
  ) u_rx_store (
    .clk       (clk),
    .req       (rx_req),
    .rd_data_r (rx_rd)
  );

  always_comb begin
    out_data              = '0;
    out_data.bus_command  = res_r.cmd;
    out_data.bus_mode     = res_r.mode;
    out_data.error_status = res_r.err;
    out_data.accepted     = res_r.acc;
    out_data.finished     = res_r.fin;
    if (res_r.tx_sel) begin
      out_data.tx_byte = res_r.tx_fwd ? res_r.tx_fwd_byte : tx_rd;
    end
    if (res_r.rx_sel) begin
      out_data.rx_data = rx_rd;
    end
  end

endmodule

### rtl/i2cms_checker.sv
// Port-level checks of the I2C master transaction sequencer, bound to the
// top level. Depends on i2cms_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cms_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input i2cms_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2cms_pkg::out_item_t out_data
);
  import i2cms_pkg::*;

  // a stalled result word holds
  `I2CMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // nothing on the output after reset
  `I2CMS_ASSERT_RST(a_rst_empty, !rst_n, !out_valid)
  // tx byte is zero unless a byte is being sent
  `I2CMS_ASSERT_NOW(a_tx_zero, out_valid && out_data.bus_command != CMD_SEND, out_data.tx_byte == 8'd0)
  // a finished transaction issues a stop and leaves the bus ready
  `I2CMS_ASSERT_NOW(a_fin_stop, out_valid && out_data.finished, out_data.bus_command == CMD_STOP && out_data.bus_mode == MODE_READY)
  // a taken start always enters initialisation and is not flagged busy
  `I2CMS_ASSERT_NOW(a_acc_init, out_valid && out_data.accepted, out_data.bus_mode == MODE_INIT && out_data.error_status != ERR_BUSY)

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker (.*);

### test/tb_i2c_master_transaction_sequencer.sv
// Testbench of the I2C master transaction sequencer: random and directed request words,
// a built-in prediction of each result word, and random idling on both channels.
// Depends on i2cms_pkg and the i2c_master_transaction_sequencer RTL.
`timescale 1ns / 1ps

module tb_i2c_master_transaction_sequencer;
  import i2cms_pkg::*;

  localparam int TXD = TX_DEPTH_DEF;
  localparam int RXD = RX_DEPTH_DEF;
  localparam int CALM_TAIL = 150;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [3:0] EV_UNUSED = 4'd15;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  in_item_t  pending_words[$];
  out_item_t result_words_due[$];
  out_item_t due_word;
  int        mismatches = 0;
  int        in_gap = 0;
  int        out_stall = 0;

  // Shadow of the sequencer state
  logic [7:0]  tx_bytes[TXD];
  bit          tx_loaded[TXD];
  logic [7:0]  rx_bytes[RXD];
  bit          rx_filled[RXD];
  bit          rx_any = 1'b0;
  int unsigned tx_total = 0;
  int unsigned tx_next = 0;
  int unsigned rx_total = 0;
  int unsigned rx_next = 0;
  mode_e       seq_mode = MODE_READY;
  err_e        seq_err = ERR_OK;
  bit          keep_bus = 1'b0;

  i2c_master_transaction_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic cmd_e launch_transfer(output logic [7:0] first_byte);
    tx_next = 0;
    first_byte = '0;
    // after a repeated start the bus is already ours: send the first byte at once
    if (seq_mode == MODE_REPSENT) begin
      seq_mode = MODE_INIT;
      first_byte = tx_bytes[0];
      tx_next = 1;
      return CMD_SEND;
    end
    seq_mode = MODE_INIT;
    return CMD_START;
  endfunction

  function automatic cmd_e end_transfer(err_e code, output bit done);
    seq_err = code;
    done = 1'b0;
    if (keep_bus)
      return CMD_START;
    seq_mode = MODE_READY;
    done = 1'b1;
    return CMD_STOP;
  endfunction

  function automatic cmd_e next_receive();
    seq_err = ERR_OK;
    if (rx_next + 1 < rx_total)
      return CMD_ACK;
    return CMD_NACK;
  endfunction

  function automatic void keep_rx(logic [7:0] b);
    // drop bytes beyond the store
    if (rx_next < RXD) begin
      rx_bytes[rx_next] = b;
      rx_filled[rx_next] = 1'b1;
      rx_any = 1'b1;
      rx_next++;
    end
  endfunction

  function automatic out_item_t sequencer_step(in_item_t w);
    out_item_t  r;
    cmd_e       cmd;
    logic [7:0] txb;
    bit         refuse;
    bit         done;
    bit         idle_ok;
    r = '0;
    cmd = CMD_NONE;
    txb = '0;
    refuse = 1'b0;
    done = 1'b0;
    idle_ok = (seq_mode == MODE_READY) || (seq_mode == MODE_REPSENT);
    case (w.operation)
      OP_LOAD_TX: begin
        if (w.index < TXD) begin
          tx_bytes[w.index] = w.data_byte;
          tx_loaded[w.index] = 1'b1;
        end
      end
      OP_START_WR: begin
        if (!idle_ok || w.length > TXD) begin
          refuse = 1'b1;
        end else begin
          r.accepted = 1'b1;
          keep_bus = w.repeated_start;
          tx_total = 32'(w.length);
          cmd = launch_transfer(txb);
        end
      end
      OP_START_RD: begin
        if (!idle_ok || w.length > RXD) begin
          refuse = 1'b1;
        end else begin
          r.accepted = 1'b1;
          rx_next = 0;
          rx_total = 32'(w.length);
          tx_bytes[0] = {w.device_address, 1'b1};
          tx_loaded[0] = 1'b1;
          tx_total = 1;
          keep_bus = w.repeated_start;
          cmd = launch_transfer(txb);
        end
      end
      OP_BUS_EVENT: begin
        case (w.event_code)
          EV_START, EV_SLAW_ACK, EV_DATA_ACK: begin
            if (w.event_code == EV_SLAW_ACK)
              seq_mode = MODE_TX;
            if (tx_next < tx_total) begin
              txb = tx_bytes[tx_next];
              tx_next++;
              seq_err = ERR_OK;
              cmd = CMD_SEND;
            end else begin
              cmd = end_transfer(ERR_OK, done);
            end
          end
          EV_SLAR_ACK: begin
            seq_mode = MODE_RX;
            cmd = next_receive();
          end
          EV_RX_ACK: begin
            keep_rx(w.data_byte);
            cmd = next_receive();
          end
          EV_RX_NACK: begin
            keep_rx(w.data_byte);
            cmd = end_transfer(ERR_OK, done);
          end
          EV_SLAR_NACK: cmd = end_transfer(ERR_SLAR_NACK, done);
          EV_SLAW_NACK: cmd = end_transfer(ERR_SLAW_NACK, done);
          EV_DATA_NACK: cmd = end_transfer(ERR_DATA_NACK, done);
          EV_ARB_LOST:  cmd = end_transfer(ERR_ARB_LOST, done);
          EV_REP_START: seq_mode = MODE_REPSENT;
          EV_ILLEGAL: begin
            seq_err = ERR_ILLEGAL;
            seq_mode = MODE_READY;
            cmd = CMD_STOP;
            done = 1'b1;
          end
          default: ;
        endcase
      end
      OP_READ_RX: begin
        if (w.index < RXD)
          r.rx_data = rx_bytes[w.index];
      end
      default: ;
    endcase
    r.bus_command = cmd;
    r.tx_byte = txb;
    r.bus_mode = seq_mode;
    if (refuse)
      r.error_status = ERR_BUSY;
    else
      r.error_status = seq_err;
    r.finished = done;
    return r;
  endfunction

  function automatic in_item_t random_word();
    logic [63:0] raw;
    in_item_t    w;
    raw = {$urandom, $urandom};
    w = raw[$bits(in_item_t)-1:0];
    return w;
  endfunction

  function automatic in_item_t make_word(logic [2:0] op, logic [3:0] ev, logic [5:0] len,
                                         logic [7:0] data, logic [6:0] addr,
                                         logic [4:0] idx, bit rep);
    in_item_t w;
    w.operation = op;
    w.event_code = ev;
    w.length = len;
    w.data_byte = data;
    w.device_address = addr;
    w.index = idx;
    w.repeated_start = rep;
    return w;
  endfunction

  // Queue a word and its predicted result; never let the block read a store entry
  // that has not been written.
  task automatic emit(input in_item_t w, output out_item_t res);
    in_item_t fill;
    int       slot;
    slot = -1;
    if (w.operation == OP_READ_RX && !rx_filled[w.index]) begin
      if (rx_any) begin
        do w.index = 5'($urandom_range(0, RXD - 1)); while (!rx_filled[w.index]);
      end else begin
        w.operation = OP_LOAD_TX;
      end
    end
    if (w.operation == OP_BUS_EVENT && (w.event_code == EV_START ||
        w.event_code == EV_SLAW_ACK || w.event_code == EV_DATA_ACK) &&
        tx_next < tx_total && !tx_loaded[tx_next])
      slot = tx_next;
    if (w.operation == OP_START_WR && seq_mode == MODE_REPSENT && w.length <= TXD &&
        !tx_loaded[0])
      slot = 0;
    if (slot >= 0) begin
      fill = random_word();
      fill.operation = OP_LOAD_TX;
      fill.index = slot[4:0];
      pending_words.push_back(fill);
      result_words_due.push_back(sequencer_step(fill));
    end
    res = sequencer_step(w);
    pending_words.push_back(w);
    result_words_due.push_back(res);
  endtask

  // One write or read as a well-behaved bus would answer it, with the odd fault
  task automatic run_transfer(bit is_read);
    in_item_t    w;
    out_item_t   res;
    cmd_e        c;
    int unsigned n;
    int unsigned pick;
    int unsigned steps;
    int unsigned i;
    bit          sent_any;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      n = 32;
    else if (pick == 1)
      n = $urandom_range(33, 63);
    else if (pick == 2)
      n = 0;
    else
      n = $urandom_range(1, 6);
    if (seq_mode != MODE_READY && seq_mode != MODE_REPSENT && $urandom_range(0, 4) != 0) begin
      w = random_word();
      w.operation = OP_BUS_EVENT;
      w.event_code = EV_ILLEGAL;
      emit(w, res);
    end
    if (!is_read) begin
      for (i = 0; i < n && i < TXD; i++) begin
        if ($urandom_range(0, 4) != 0) begin
          w = random_word();
          w.operation = OP_LOAD_TX;
          w.index = 5'(i);
          emit(w, res);
        end
      end
    end
    w = random_word();
    w.operation = is_read ? OP_START_RD : OP_START_WR;
    w.length = 6'(n);
    w.repeated_start = ($urandom_range(0, 3) == 0);
    emit(w, res);
    c = cmd_e'(res.bus_command);
    sent_any = 1'b0;
    steps = 0;
    while (c != CMD_STOP && c != CMD_NONE && steps < 80) begin
      steps++;
      if ($urandom_range(0, 29) == 0) begin
        // stray software word mid-transfer: a start here is refused
        w = random_word();
        w.operation = $urandom_range(0, 1) ? OP_READ_RX : (is_read ? OP_START_WR : OP_START_RD);
        emit(w, res);
      end
      w = random_word();
      w.operation = OP_BUS_EVENT;
      case (c)
        CMD_START: w.event_code = (steps == 1) ? EV_START : EV_REP_START;
        CMD_SEND: begin
          w.event_code = !sent_any ? (is_read ? EV_SLAR_ACK : EV_SLAW_ACK) : EV_DATA_ACK;
          sent_any = 1'b1;
        end
        CMD_ACK: w.event_code = EV_RX_ACK;
        default: w.event_code = ($urandom_range(0, 9) == 0) ? EV_RX_ACK : EV_RX_NACK;
      endcase
      if (c != CMD_START && $urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 4))
          0: w.event_code = EV_SLAW_NACK;
          1: w.event_code = EV_DATA_NACK;
          2: w.event_code = EV_ARB_LOST;
          3: w.event_code = EV_SLAR_NACK;
          default: w.event_code = EV_ILLEGAL;
        endcase
      end
      emit(w, res);
      // bus kept: hand back to software after the repeated start
      if (w.event_code == EV_REP_START)
        c = CMD_NONE;
      else
        c = cmd_e'(res.bus_command);
    end
  endtask

  task automatic compare_field(string label, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
          if (pending_words.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
            in_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (result_words_due.size() == 0) begin
          $display("%0t: result word with nothing due, actual %h", $time, out_data);
          mismatches++;
        end else begin
          due_word = result_words_due.pop_front();
          compare_field("bus_command", 8'(due_word.bus_command),
                        8'(out_data.bus_command));
          compare_field("tx_byte", due_word.tx_byte, out_data.tx_byte);
          compare_field("rx_data", due_word.rx_data, out_data.rx_data);
          compare_field("bus_mode", 8'(due_word.bus_mode), 8'(out_data.bus_mode));
          compare_field("error_status", 8'(due_word.error_status),
                        8'(out_data.error_status));
          compare_field("accepted", 8'(due_word.accepted), 8'(out_data.accepted));
          compare_field("finished", 8'(due_word.finished), 8'(out_data.finished));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (pending_words.size() >= CALM_TAIL && $urandom_range(0, 9) == 0)
          out_stall = $urandom_range(1, 12);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    in_item_t    w;
    out_item_t   scratch;
    int unsigned sel;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;

    // directed: extremes, refusals, zero-length read, repeated start, faults
    emit(make_word(OP_LOAD_TX, EV_NONE, 6'd0, 8'hFF, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_LOAD_TX, EV_NONE, 6'd0, 8'h00, 7'd0, 5'd31, 1'b0), scratch);
    emit(make_word(OP_LOAD_TX, EV_NONE, 6'd0, 8'h5A, 7'd0, 5'd1, 1'b0), scratch);
    emit(make_word(OP_START_WR, EV_NONE, 6'd33, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_START_WR, EV_NONE, 6'd2, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_BUS_EVENT, EV_START, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_START_RD, EV_NONE, 6'd1, 8'h00, 7'd9, 5'd0, 1'b0), scratch);
    emit(make_word(OP_BUS_EVENT, EV_SLAW_ACK, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_BUS_EVENT, EV_DATA_ACK, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_START_RD, EV_NONE, 6'd0, 8'h00, 7'd127, 5'd0, 1'b1), scratch);
    emit(make_word(OP_BUS_EVENT, EV_START, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_BUS_EVENT, EV_SLAR_ACK, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_BUS_EVENT, EV_RX_NACK, 6'd0, 8'hFF, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_BUS_EVENT, EV_REP_START, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_START_WR, EV_NONE, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_BUS_EVENT, EV_SLAW_ACK, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_READ_RX, EV_NONE, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_BUS_EVENT, EV_NONE, 6'd63, 8'hFF, 7'd127, 5'd31, 1'b1), scratch);
    emit(make_word(OP_UNUSED, EV_UNUSED, 6'd63, 8'hFF, 7'd127, 5'd31, 1'b1), scratch);
    emit(make_word(OP_BUS_EVENT, EV_UNUSED, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_BUS_EVENT, EV_ILLEGAL, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_START_RD, EV_NONE, 6'd32, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_BUS_EVENT, EV_ARB_LOST, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);
    emit(make_word(OP_BUS_EVENT, EV_SLAW_NACK, 6'd0, 8'h00, 7'd0, 5'd0, 1'b0), scratch);

    while (pending_words.size() < 1000) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        run_transfer(1'b0);
      end else if (sel < 75) begin
        run_transfer(1'b1);
      end else if (sel < 85) begin
        w = random_word();
        w.operation = OP_READ_RX;
        emit(w, scratch);
      end else begin
        emit(random_word(), scratch);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid)
      @(posedge clk);
    while (result_words_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
